// ----- rtl/core/qmi_pkg.sv -----
// qmi_pkg: shared types and constants for the queue machine interpreter
// no dependencies
package qmi_pkg;
    localparam int QUEUE_DEPTH   = 1024;
    localparam int PROGRAM_DEPTH = 65536;
    localparam int QAW           = $clog2(QUEUE_DEPTH);
    localparam int QCW           = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_REGS      = 26;
    localparam int RAW           = 5;

    typedef enum logic [4:0] {
        M_PUSH = 5'd0, M_ADD = 5'd1, M_SUB = 5'd2, M_MUL = 5'd3, M_DIV = 5'd4,
        M_MOD = 5'd5, M_STORE = 5'd6, M_LOAD = 5'd7, M_PRINTQ = 5'd8,
        M_PRINTR = 5'd9, M_CHARQ = 5'd10, M_CHARR = 5'd11, M_LABEL = 5'd12,
        M_JUMP = 5'd13, M_JZ = 5'd14, M_JEQ = 5'd15, M_JGT = 5'd16, M_QUIT = 5'd17
    } t_mode;

    typedef enum logic [1:0] {
        F_NONE = 2'd0, F_UNDER = 2'd1, F_OVER = 2'd2
    } t_fault;

    typedef enum logic [2:0] {
        S_IDLE, S_POPA, S_POPB, S_DIV, S_EXEC, S_OUT
    } t_state;

    typedef struct packed {
        logic [4:0]  mode;
        logic [4:0]  reg_first;
        logic [4:0]  reg_second;
        logic [15:0] immediate;
        logic [15:0] target;
    } t_in;

    typedef struct packed {
        logic        out_valid;
        logic [15:0] out_value;
        logic        out_is_char;
        logic [15:0] next_pc;
        logic        halted;
        logic [1:0]  fault;
    } t_out;

    typedef struct packed {
        logic        start;
        logic [15:0] a;
        logic [15:0] b;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
        logic [15:0] rem;
    } t_div_rsp;
endpackage

// ----- rtl/core/qmi_if.sv -----
// qmi_in_if, qmi_out_if: valid/ready channels carrying items
// depends on qmi_pkg
interface qmi_in_if;
    import qmi_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qmi_out_if;
    import qmi_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/qmi_div.sv -----
// qmi_div: 16-bit restoring divider, one quotient bit per cycle
// depends on qmi_pkg
module qmi_div
    import qmi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [15:0] r_q, n_q, r_b;
    logic [16:0] r_r, n_r, tr;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;

    always_comb begin
        tr  = {r_r[15:0], r_q[15]};
        n_q = {r_q[14:0], 1'b0};
        n_r = tr;
        if (tr >= {1'b0, r_b}) begin
            n_r     = tr - {1'b0, r_b};
            n_q[0]  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q <= i_req.a;
            r_b <= i_req.b;
            r_r <= '0;
        end else if (r_busy) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = (r_b == 16'd0) ? 16'd0 : r_q;
    assign o_rsp.rem  = (r_b == 16'd0) ? 16'd0 : r_r[15:0];
endmodule

// ----- rtl/core/qmi_queue_mem.sv -----
// qmi_queue_mem: word store of the queue, one write and one registered read port
// depends on qmi_pkg
module qmi_queue_mem
    import qmi_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [QAW-1:0] i_waddr,
    input  logic [15:0]    i_wdata,
    input  logic [QAW-1:0] i_raddr,
    output logic [15:0]    o_rdata
);
    logic [15:0] mem [QUEUE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ----- rtl/core/queue_machine_interpreter.sv -----
// queue_machine_interpreter: top level, sequencer, registers and result stage
// depends on qmi_pkg, qmi_if, qmi_queue_mem, qmi_div
//
// usage: one decoded instruction per input item on i_in, one result item per
// instruction on o_out, both valid/ready. last_address is written through
// i_cfg_we / i_cfg_data while the block is idle.
// the queue words sit in a synchronous ram with a registered read port; each
// pop is one ram read and the popped word is used in the cycle after.
// every item passes the pop-a and execute states before its result is
// registered; while not halted, add, sub and mul also pass pop-b, and
// div and mod pass pop-b and wait in the div state for the bit-serial
// divider. the result is held in an output register; a new item is taken
// only once it has been handed on, so items do not overlap and a stalled
// receiver holds the block.
// the halted state persists; further items return the held pc.
// reset clears head, tail, count, registers, pc, halt and last_address;
// queue contents need no clearing as an entry is read only after written.
module queue_machine_interpreter
    import qmi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    qmi_in_if.sink     i_in,
    qmi_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    t_state r_state, n_state;
    t_in    r_ins;
    t_out   r_res;
    logic   r_ovalid;
    logic [15:0] r_last, r_pc;
    logic        r_halt;
    logic [QAW-1:0] r_head, r_tail;
    logic [QCW-1:0] r_count;
    logic [15:0] r_regs [NUM_REGS];
    logic [15:0] r_a;
    logic [1:0]  r_fault;
    logic        r_pend;
    logic        r_dstart;

    logic [15:0] rdata;
    logic [15:0] pop_val;
    logic        mem_we;
    logic [15:0] mem_wd;
    t_div_req    dreq;
    t_div_rsp    drsp;

    qmi_queue_mem u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(r_tail), .i_wdata(mem_wd),
        .i_raddr(r_head), .o_rdata(rdata)
    );

    qmi_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(dreq), .o_rsp(drsp));

    function automatic logic [15:0] rd(input logic [15:0] rf [NUM_REGS], input logic [4:0] i);
        rd = (i < RAW'(NUM_REGS)) ? rf[i] : 16'd0;
    endfunction

    t_mode m;
    logic  is_arith, one_pop;
    logic [15:0] ra, rb, push_v, value, dvalue;
    logic  do_push, taken, quit;
    logic [16:0] nxt;

    assign m        = t_mode'(r_ins.mode);
    assign is_arith = (m == M_ADD) || (m == M_SUB) || (m == M_MUL) ||
                      (m == M_DIV) || (m == M_MOD);
    assign one_pop  = (m == M_STORE) || (m == M_PRINTQ) || (m == M_CHARQ);
    assign ra       = rd(r_regs, r_ins.reg_first);
    assign rb       = rd(r_regs, r_ins.reg_second);
    assign i_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in.valid && i_in.ready) n_state = S_POPA;
            S_POPA:  n_state = (r_halt || !(is_arith || one_pop)) ? S_EXEC :
                               (is_arith ? S_POPB : S_EXEC);
            S_POPB:  n_state = ((m == M_DIV) || (m == M_MOD)) ? S_DIV : S_EXEC;
            S_DIV:   if (drsp.done) n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // pop step: value becomes valid next cycle from ram
    logic pop_now;
    assign pop_now = !r_halt && ((r_state == S_POPA && (is_arith || one_pop)) ||
                                 (r_state == S_POPB));

    assign pop_val = r_pend ? rdata : 16'd0;

    always_comb begin
        push_v  = 16'd0;
        do_push = 1'b0;
        value   = 16'd0;
        taken   = 1'b0;
        quit    = 1'b0;
        dvalue  = (m == M_DIV) ? drsp.quot : drsp.rem;
        case (m)
            M_PUSH:   begin do_push = 1'b1; push_v = r_ins.immediate; end
            M_ADD:    begin do_push = 1'b1; push_v = r_a + pop_val; end
            M_SUB:    begin do_push = 1'b1; push_v = r_a - pop_val; end
            M_MUL:    begin do_push = 1'b1; push_v = 16'(r_a * pop_val); end
            M_DIV,
            M_MOD:    begin do_push = 1'b1; push_v = dvalue; end
            M_LOAD:   begin do_push = 1'b1; push_v = ra; end
            M_PRINTQ: value = pop_val;
            M_PRINTR: value = ra;
            M_CHARQ:  value = {8'd0, pop_val[7:0]};
            M_CHARR:  value = {8'd0, ra[7:0]};
            M_JUMP:   taken = 1'b1;
            M_JZ:     taken = (ra == 16'd0);
            M_JEQ:    taken = (ra == rb);
            M_JGT:    taken = (ra > rb);
            M_QUIT:   quit = 1'b1;
            default:  ;
        endcase
        if (quit)       nxt = {1'b0, r_last} + 17'd1;
        else if (taken) nxt = {1'b0, r_ins.target} + 17'd1;
        else            nxt = {1'b0, r_pc} + 17'd1;
    end

    logic exec, push_ok;
    assign exec    = (r_state == S_EXEC) && !r_halt;
    assign push_ok = do_push && (r_count != QCW'(QUEUE_DEPTH));
    assign mem_we  = exec && push_ok;
    assign mem_wd  = push_v;

    // divider starts in the first div cycle, second operand straight from ram
    assign dreq.start = r_dstart;
    assign dreq.a     = r_a;
    assign dreq.b     = pop_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_last   <= '0;
            r_pc     <= '0;
            r_halt   <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_fault  <= F_NONE;
            r_pend   <= 1'b0;
            r_dstart <= 1'b0;
            for (int k = 0; k < NUM_REGS; k++) r_regs[k] <= '0;
        end else begin
            r_state  <= n_state;
            r_dstart <= (r_state == S_POPB) && (n_state == S_DIV);
            if (i_cfg_we) r_last <= i_cfg_data;
            if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            if (i_in.valid && i_in.ready) begin
                r_ins   <= i_in.data;
                r_fault <= F_NONE;
                r_a     <= '0;
            end
            r_pend <= pop_now && (r_count != '0);
            if (pop_now) begin
                if (r_count == '0) begin
                    r_fault <= F_UNDER;
                end else begin
                    r_head  <= (r_head == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    r_count <= r_count - 1'b1;
                end
            end
            // first popped word of an arithmetic item
            if (r_state == S_POPB) r_a <= pop_val;
            if (exec) begin
                if (do_push) begin
                    if (push_ok) begin
                        r_tail  <= (r_tail == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                        r_count <= r_count + 1'b1;
                    end else if (r_fault == F_NONE) begin
                        r_fault <= F_OVER;
                    end
                end
                if (m == M_STORE && r_ins.reg_first < RAW'(NUM_REGS))
                    r_regs[r_ins.reg_first] <= pop_val;
                r_pc <= nxt[15:0];
                if (quit || nxt > {1'b0, r_last} || nxt >= 17'(PROGRAM_DEPTH))
                    r_halt <= 1'b1;
            end
            if (r_state == S_EXEC) r_ovalid <= 1'b1;
        end
    end

    logic [1:0] res_fault;
    always_comb begin
        res_fault = r_fault;
        if (exec && do_push && !push_ok && r_fault == F_NONE) res_fault = F_OVER;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            if (r_halt) begin
                r_res <= '{out_valid: 1'b0, out_value: 16'd0, out_is_char: 1'b0,
                           next_pc: r_pc, halted: 1'b1, fault: F_NONE};
            end else begin
                r_res.out_valid   <= (m == M_PRINTQ) || (m == M_PRINTR) ||
                                     (m == M_CHARQ) || (m == M_CHARR);
                r_res.out_value   <= value;
                r_res.out_is_char <= (m == M_CHARQ) || (m == M_CHARR);
                r_res.next_pc     <= nxt[15:0];
                r_res.halted      <= quit || nxt > {1'b0, r_last} ||
                                     nxt >= 17'(PROGRAM_DEPTH);
                r_res.fault       <= res_fault;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready) else $error("ready while busy");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QUEUE_DEPTH)) else $error("count beyond depth");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt) else $error("halt cleared");
`endif
endmodule
